@@ rtl/core/rotation_matrix_to_euler_angles_defines.svh @@
// Assertion macros shared by the checker files of the Euler angle block.
// No dependencies; each macro samples on clk and is disabled while arst_n is low.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define RMTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RMTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rmte_pkg.sv @@
// Types, constants and small functions for the rotation matrix to Euler angle block.
// No dependencies; used by the sqrt cell, the CORDIC cell and the top level.
`default_nettype none

package rmte_pkg;

	localparam int ENTRY_W = 16;
	localparam int ANGLE_W = 16;
	localparam int VEC_W   = 26;
	localparam int Z_W     = 20;
	localparam int SQ_W    = 31;
	localparam int STEPS   = 16;

	localparam int UNIT_Q14    = 16384;
	localparam int ANGLE_MAX   = 25736;
	localparam int HALF_PI_Q16 = 102944;

	// order code bit positions
	localparam int ORD_FRAME  = 0;
	localparam int ORD_REPEAT = 1;
	localparam int ORD_PARITY = 2;
	localparam int ORD_AXIS   = 3;

	// configuration register indexes
	localparam logic CFG_ORDER     = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [Z_W-1:0]     zang_t;
	typedef logic signed [VEC_W-1:0]   coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		zang_t  z;
	} vec_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		entry_t p;
		entry_t a1n_y;
		entry_t a1n_x;
		entry_t a1f_y;
		entry_t a1f_x;
		entry_t a3_y;
		entry_t a3_x;
		logic   rep;
		logic   par;
		logic   fr;
	} side_t;

	typedef struct packed {
		logic par;
		logic fr;
		logic degen;
	} flag_t;

	// CORDIC arctangent table, Q16 radians
	function automatic zang_t arc_angle(input int unsigned step);
		zang_t a;
		case (step)
			0:       a = 20'sd51472;
			1:       a = 20'sd30386;
			2:       a = 20'sd16055;
			3:       a = 20'sd8150;
			4:       a = 20'sd4091;
			5:       a = 20'sd2047;
			6:       a = 20'sd1024;
			7:       a = 20'sd512;
			8:       a = 20'sd256;
			9:       a = 20'sd128;
			10:      a = 20'sd64;
			11:      a = 20'sd32;
			12:      a = 20'sd16;
			13:      a = 20'sd8;
			14:      a = 20'sd4;
			15:      a = 20'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

	// cyclic successor of an axis
	function automatic logic [1:0] axis_next(input logic [1:0] idx);
		logic [1:0] n;
		case (idx)
			2'd0:    n = 2'd1;
			2'd1:    n = 2'd2;
			2'd2:    n = 2'd0;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

	// scale by 256 and turn left half-plane vectors into the right half-plane
	function automatic vec_t prerot(input entry_t y, input entry_t x);
		vec_t   v;
		coord_t xs;
		coord_t ys;
		xs = {{(VEC_W-ENTRY_W-8){x[ENTRY_W-1]}}, x, 8'd0};
		ys = {{(VEC_W-ENTRY_W-8){y[ENTRY_W-1]}}, y, 8'd0};
		if (x < 0) begin
			if (y >= 0) begin
				v.x = ys;
				v.y = -xs;
				v.z = Z_W'(HALF_PI_Q16);
			end else begin
				v.x = -ys;
				v.y = xs;
				v.z = -Z_W'(HALF_PI_Q16);
			end
		end else begin
			v.x = xs;
			v.y = ys;
			v.z = '0;
		end
		return v;
	endfunction

	// Q16 angle to rounded, saturated Q3.13
	function automatic angle_t finish_angle(input zang_t z);
		zang_t r;
		angle_t a;
		r = (z + zang_t'(4)) >>> 3;
		if (r > zang_t'(ANGLE_MAX))
			a = angle_t'(ANGLE_MAX);
		else if (r < -zang_t'(ANGLE_MAX))
			a = -angle_t'(ANGLE_MAX);
		else
			a = r[ANGLE_W-1:0];
		return a;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rmte_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
// Depends on rmte_pkg for the sqrt_t partial result type.
`default_nettype none

module rmte_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  rmte_pkg::sqrt_t     d,
	output rmte_pkg::sqrt_t     q
);

	localparam logic [rmte_pkg::SQ_W-1:0] BIT =
		rmte_pkg::SQ_W'(1) << (rmte_pkg::SQ_W - 1 - 2 * STEP);

	logic [rmte_pkg::SQ_W:0] trial;

	// try the next result bit against the remainder
	assign trial = {1'b0, d.root} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, d.rem} >= trial) begin
				q.rem  <= d.rem - trial[rmte_pkg::SQ_W-1:0];
				q.root <= (d.root >> 1) + BIT;
			end else begin
				q.rem  <= d.rem;
				q.root <= d.root >> 1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rmte_cordic_cell.sv @@
// One vectoring CORDIC iteration with its own shift and arctangent constant.
// Depends on rmte_pkg for vec_t and the arctangent table.
`default_nettype none

module rmte_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic       clk,
	input  wire logic       en,
	input  rmte_pkg::vec_t  d,
	output rmte_pkg::vec_t  q
);

	localparam rmte_pkg::zang_t ARC = rmte_pkg::arc_angle(STEP);

	rmte_pkg::coord_t xs;
	rmte_pkg::coord_t ys;

	assign xs = d.x >>> STEP;
	assign ys = d.y >>> STEP;

	// rotate toward the x axis, hold when already on it
	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y > 0) begin
				q.x <= d.x + ys;
				q.y <= d.y - xs;
				q.z <= d.z + ARC;
			end else if (d.y < 0) begin
				q.x <= d.x - ys;
				q.y <= d.y + xs;
				q.z <= d.z - ARC;
			end else begin
				q <= d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rotation_matrix_to_euler_angles.sv @@
// Rotation matrix (Q1.14) to Euler angles (Q3.13 radians) for all 24 axis orders.
// Accepts one matrix per cycle while in_stall is low. The pipeline is a 16-cell
// square root row followed by three parallel 16-cell CORDIC rows (second angle,
// first angle, third angle), plus an entry select stage, a squaring stage, an
// operand select stage and the output register. A one-item skid buffer behind
// the output register keeps the pipeline moving while a result waits; in_stall
// rises only when both are full. The user must write configuration (order code,
// near-zero threshold) only while idle; the block itself does not enforce this.
// Depends on rmte_pkg, rmte_sqrt_cell and rmte_cordic_cell.
`default_nettype none

module rotation_matrix_to_euler_angles #(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [14:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r0_c0,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r0_c1,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r0_c2,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r1_c0,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r1_c1,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r1_c2,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r2_c0,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r2_c1,
	input  wire logic signed [DATA_WIDTH-1:0]  m_r2_c2,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output rmte_pkg::angle_t                   angle_first,
	output rmte_pkg::angle_t                   angle_second,
	output rmte_pkg::angle_t                   angle_third
);

	localparam int EXT_W = ((DATA_WIDTH > 15) ? DATA_WIDTH : 15) + 1;
	localparam int STEPS = rmte_pkg::STEPS;
	localparam int SIDE_N = STEPS + 2;
	localparam int PIPE_N = 2 * STEPS + 3;

	localparam logic signed [EXT_W-1:0] UNIT_EXT = EXT_W'(rmte_pkg::UNIT_Q14);

	function automatic rmte_pkg::entry_t clamp_entry(
		input logic signed [DATA_WIDTH-1:0] v
	);
		logic signed [EXT_W-1:0] w;
		rmte_pkg::entry_t r;
		w = {{(EXT_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
		if (w > UNIT_EXT)
			r = rmte_pkg::entry_t'(rmte_pkg::UNIT_Q14);
		else if (w < -UNIT_EXT)
			r = -rmte_pkg::entry_t'(rmte_pkg::UNIT_Q14);
		else
			r = w[rmte_pkg::ENTRY_W-1:0];
		return r;
	endfunction

	// configuration registers
	logic [4:0]  order_q;
	logic [14:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 5'd12;
			thr_q   <= 15'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				rmte_pkg::CFG_ORDER:     order_q <= cfg_data[4:0];
				rmte_pkg::CFG_THRESHOLD: thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic              en;
	logic              skid_q;
	logic [PIPE_N-1:0] vld_q;

	assign en       = !skid_q;
	assign in_stall = skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_N-2:0], in_valid};
	end

	// clamp and pick the entries for the current axis order
	rmte_pkg::entry_t ent [3][3];
	logic [1:0]       ax;
	logic [1:0]       ai;
	logic [1:0]       aj;
	logic [1:0]       ak;
	logic             o_rep;
	logic             o_par;
	rmte_pkg::side_t  side_d;
	rmte_pkg::entry_t sa_d;
	rmte_pkg::entry_t sb_d;

	always_comb begin
		ent[0][0] = clamp_entry(m_r0_c0);
		ent[0][1] = clamp_entry(m_r0_c1);
		ent[0][2] = clamp_entry(m_r0_c2);
		ent[1][0] = clamp_entry(m_r1_c0);
		ent[1][1] = clamp_entry(m_r1_c1);
		ent[1][2] = clamp_entry(m_r1_c2);
		ent[2][0] = clamp_entry(m_r2_c0);
		ent[2][1] = clamp_entry(m_r2_c1);
		ent[2][2] = clamp_entry(m_r2_c2);
	end

	always_comb begin
		o_rep = order_q[rmte_pkg::ORD_REPEAT];
		o_par = order_q[rmte_pkg::ORD_PARITY];
		ax    = order_q[rmte_pkg::ORD_AXIS +: 2];
		case (ax)
			2'd1:    ai = 2'd1;
			2'd2:    ai = 2'd2;
			default: ai = 2'd0;
		endcase
		aj = rmte_pkg::axis_next(ai + {1'b0, o_par});
		ak = rmte_pkg::axis_next(ai + 2'd1 - {1'b0, o_par});

		side_d.rep   = o_rep;
		side_d.par   = o_par;
		side_d.fr    = order_q[rmte_pkg::ORD_FRAME];
		side_d.a1f_y = -ent[aj][ak];
		side_d.a1f_x = ent[aj][aj];
		if (o_rep) begin
			sa_d         = ent[ai][aj];
			sb_d         = ent[ai][ak];
			side_d.p     = ent[ai][ai];
			side_d.a1n_y = ent[ai][aj];
			side_d.a1n_x = ent[ai][ak];
			side_d.a3_y  = ent[aj][ai];
			side_d.a3_x  = -ent[ak][ai];
		end else begin
			sa_d         = ent[ai][ai];
			sb_d         = ent[aj][ai];
			side_d.p     = -ent[ak][ai];
			side_d.a1n_y = ent[ak][aj];
			side_d.a1n_x = ent[ak][ak];
			side_d.a3_y  = ent[aj][ai];
			side_d.a3_x  = ent[ai][ai];
		end
	end

	// entry select stage and side data delay line
	rmte_pkg::side_t  side_q [SIDE_N];
	rmte_pkg::entry_t sa_s0;
	rmte_pkg::entry_t sb_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s0     <= sa_d;
			sb_s0     <= sb_d;
			side_q[0] <= side_d;
			for (int i = 1; i < SIDE_N; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// square and sum
	logic signed [31:0]          sq_a;
	logic signed [31:0]          sq_b;
	logic [rmte_pkg::SQ_W-1:0]   sum_s1;

	assign sq_a = sa_s0 * sa_s0;
	assign sq_b = sb_s0 * sb_s0;

	always_ff @(posedge clk) begin
		if (en)
			sum_s1 <= rmte_pkg::SQ_W'(sq_a + sq_b);
	end

	// square root row
	rmte_pkg::sqrt_t sq [STEPS+1];

	assign sq[0].rem  = sum_s1;
	assign sq[0].root = '0;

	for (genvar g = 0; g < STEPS; g++) begin : g_sqrt
		rmte_sqrt_cell #(.STEP(g)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq[g]),
			.q   (sq[g+1])
		);
	end

	// operand select for the three arctangent rows
	rmte_pkg::side_t  side_n;
	rmte_pkg::entry_t nrm;
	logic             degen;
	rmte_pkg::vec_t   cv [3][STEPS+1];
	rmte_pkg::flag_t  flg_q [STEPS+1];

	assign side_n = side_q[SIDE_N-1];
	assign nrm    = sq[STEPS].root[rmte_pkg::ENTRY_W-1:0];
	assign degen  = ({1'b0, thr_q} >= nrm);

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_n.rep)
				cv[0][0] <= rmte_pkg::prerot(nrm, side_n.p);
			else
				cv[0][0] <= rmte_pkg::prerot(side_n.p, nrm);
			if (degen)
				cv[1][0] <= rmte_pkg::prerot(side_n.a1f_y, side_n.a1f_x);
			else
				cv[1][0] <= rmte_pkg::prerot(side_n.a1n_y, side_n.a1n_x);
			cv[2][0]       <= rmte_pkg::prerot(side_n.a3_y, side_n.a3_x);
			flg_q[0].par   <= side_n.par;
			flg_q[0].fr    <= side_n.fr;
			flg_q[0].degen <= degen;
			for (int i = 1; i <= STEPS; i++)
				flg_q[i] <= flg_q[i-1];
		end
	end

	// CORDIC rows: lane 0 second angle, lane 1 first angle, lane 2 third angle
	for (genvar l = 0; l < 3; l++) begin : g_lane
		for (genvar g = 0; g < STEPS; g++) begin : g_step
			rmte_cordic_cell #(.STEP(g)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (cv[l][g]),
				.q   (cv[l][g+1])
			);
		end
	end

	// round, zero the third angle when degenerate, apply parity and frame
	rmte_pkg::flag_t  flg_n;
	rmte_pkg::angle_t r1;
	rmte_pkg::angle_t r2;
	rmte_pkg::angle_t r3;
	rmte_pkg::angle_t f1;
	rmte_pkg::angle_t f2;
	rmte_pkg::angle_t f3;

	always_comb begin
		flg_n = flg_q[STEPS];
		r2 = rmte_pkg::finish_angle(cv[0][STEPS].z);
		r1 = rmte_pkg::finish_angle(cv[1][STEPS].z);
		r3 = flg_n.degen ? '0 : rmte_pkg::finish_angle(cv[2][STEPS].z);
		if (flg_n.par) begin
			r1 = -r1;
			r2 = -r2;
			r3 = -r3;
		end
		f2 = r2;
		f1 = flg_n.fr ? r3 : r1;
		f3 = flg_n.fr ? r1 : r3;
	end

	// output register with one-item skid
	logic             take_out;
	logic             arrive;
	rmte_pkg::angle_t skid1_q;
	rmte_pkg::angle_t skid2_q;
	rmte_pkg::angle_t skid3_q;

	assign take_out = out_valid && !out_stall;
	assign arrive   = en && vld_q[PIPE_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_q    <= 1'b0;
		end else if (skid_q) begin
			if (take_out)
				skid_q <= 1'b0;
		end else if (!out_valid || take_out) begin
			out_valid <= arrive;
		end else if (arrive) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_q) begin
			if (take_out) begin
				angle_first  <= skid1_q;
				angle_second <= skid2_q;
				angle_third  <= skid3_q;
			end
		end else if (!out_valid || take_out) begin
			angle_first  <= f1;
			angle_second <= f2;
			angle_third  <= f3;
		end else begin
			skid1_q <= f1;
			skid2_q <= f2;
			skid3_q <= f3;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/rmte_checker.sv @@
// Port-level checks for the rotation matrix to Euler angle block, bound to its top.
// Depends on rotation_matrix_to_euler_angles_defines.svh for the assertion macros.
`default_nettype none

`include "rotation_matrix_to_euler_angles_defines.svh"

module rmte_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] angle_first,
	input wire logic signed [15:0] angle_second,
	input wire logic signed [15:0] angle_third
);

	logic in_range;

	// all three angles within plus or minus pi
	assign in_range = angle_first <= 16'sd25736 && angle_first >= -16'sd25736 &&
		angle_second <= 16'sd25736 && angle_second >= -16'sd25736 &&
		angle_third <= 16'sd25736 && angle_third >= -16'sd25736;

	// a stalled result stays offered
	`RMTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// input stalls only behind a held result
	`RMTE_ASSERT(a_stall_needs_out, !out_valid |-> !in_stall, "input stalled with empty output")

	// skid fills only when the output was stalled
	`RMTE_ASSERT(a_skid_cause, $rose(in_stall) |-> $past(out_valid && out_stall), "skid w/o stall")

	// angles stay within plus or minus pi
	`RMTE_ASSERT(a_range, out_valid |-> in_range, "angle out of range")

endmodule

bind rotation_matrix_to_euler_angles rmte_checker u_rmte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.angle_first  (angle_first),
	.angle_second (angle_second),
	.angle_third  (angle_third)
);

`default_nettype wire

@@ bench/euler_angle_checker.sv @@
`timescale 1ns / 100ps
// Checker for the rotation matrix to Euler angle block: predicts angles per matrix.
// Depends on rmte_pkg; watches the input and output channels and counts failures.
`default_nettype none

module euler_angle_checker (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [14:0]             cfg_data,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic signed [15:0]      m_r0_c0,
	input  wire logic signed [15:0]      m_r0_c1,
	input  wire logic signed [15:0]      m_r0_c2,
	input  wire logic signed [15:0]      m_r1_c0,
	input  wire logic signed [15:0]      m_r1_c1,
	input  wire logic signed [15:0]      m_r1_c2,
	input  wire logic signed [15:0]      m_r2_c0,
	input  wire logic signed [15:0]      m_r2_c1,
	input  wire logic signed [15:0]      m_r2_c2,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire rmte_pkg::angle_t        angle_first,
	input  wire rmte_pkg::angle_t        angle_second,
	input  wire rmte_pkg::angle_t        angle_third,
	output int                           fail_count,
	output int                           angles_pending
);
	import rmte_pkg::*;

	typedef struct packed {
		angle_t first;
		angle_t second;
		angle_t third;
	} euler_t;

	euler_t       expected_angles[$];
	logic [4:0]   order_reg;
	logic [14:0]  lock_thresh;

	assign angles_pending = expected_angles.size();

	function automatic longint clamp_entry(input logic signed [15:0] raw);
		longint s;
		s = raw;
		if (s > UNIT_Q14) s = UNIT_Q14;
		if (s < -UNIT_Q14) s = -UNIT_Q14;
		return s;
	endfunction

	function automatic longint isqrt(input longint a, input longint b);
		longint n;
		longint r;
		n = a * a + b * b;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return r;
	endfunction

	function automatic longint cordic_atan(input longint yin, input longint xin);
		longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		longint x;
		longint y;
		longint z;
		longint t;
		longint xs;
		longint ys;
		x = xin * 256;
		y = yin * 256;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Q16;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += tab[i];
			end else if (y < 0) begin
				x -= ys; y += xs; z -= tab[i];
			end
		end
		z = (z + 4) >>> 3;
		if (z > ANGLE_MAX) z = ANGLE_MAX;
		if (z < -ANGLE_MAX) z = -ANGLE_MAX;
		return z;
	endfunction

	function automatic euler_t predict_angles(input longint m[3][3]);
		int unsigned ai;
		int unsigned aj;
		int unsigned ak;
		int unsigned nxt[4] = '{1, 2, 0, 1};
		logic        par;
		longint      nrm;
		longint      a1;
		longint      a2;
		longint      a3;
		longint      t;
		euler_t      e;
		par = order_reg[ORD_PARITY];
		ai = (order_reg[4:3] == 2'd3) ? 0 : order_reg[4:3];
		aj = nxt[ai + par];
		ak = nxt[ai + 1 - par];
		if (order_reg[ORD_REPEAT]) begin
			nrm = isqrt(m[ai][aj], m[ai][ak]);
			a2 = cordic_atan(nrm, m[ai][ai]);
			if (nrm > lock_thresh) begin
				a1 = cordic_atan(m[ai][aj], m[ai][ak]);
				a3 = cordic_atan(m[aj][ai], -m[ak][ai]);
			end else begin
				a1 = cordic_atan(-m[aj][ak], m[aj][aj]);
				a3 = 0;
			end
		end else begin
			nrm = isqrt(m[ai][ai], m[aj][ai]);
			a2 = cordic_atan(-m[ak][ai], nrm);
			if (nrm > lock_thresh) begin
				a1 = cordic_atan(m[ak][aj], m[ak][ak]);
				a3 = cordic_atan(m[aj][ai], m[ai][ai]);
			end else begin
				a1 = cordic_atan(-m[aj][ak], m[aj][aj]);
				a3 = 0;
			end
		end
		if (par) begin
			a1 = -a1; a2 = -a2; a3 = -a3;
		end
		if (order_reg[ORD_FRAME]) begin
			t = a1; a1 = a3; a3 = t;
		end
		e.first = angle_t'(a1);
		e.second = angle_t'(a2);
		e.third = angle_t'(a3);
		return e;
	endfunction

	// track registers, predict on accepted items, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		longint mat[3][3];
		euler_t want;
		int     errs;
		if (!arst_n) begin
			order_reg   <= 5'd12;
			lock_thresh <= 15'd1;
			fail_count  <= 0;
			expected_angles.delete();
		end else begin
			errs = 0;
			if (cfg_we) begin
				if (cfg_index == CFG_ORDER) order_reg <= cfg_data[4:0];
				else lock_thresh <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				mat[0][0] = clamp_entry(m_r0_c0);
				mat[0][1] = clamp_entry(m_r0_c1);
				mat[0][2] = clamp_entry(m_r0_c2);
				mat[1][0] = clamp_entry(m_r1_c0);
				mat[1][1] = clamp_entry(m_r1_c1);
				mat[1][2] = clamp_entry(m_r1_c2);
				mat[2][0] = clamp_entry(m_r2_c0);
				mat[2][1] = clamp_entry(m_r2_c1);
				mat[2][2] = clamp_entry(m_r2_c2);
				expected_angles.push_back(predict_angles(mat));
			end
			if (out_valid && !out_stall) begin
				if (expected_angles.size() == 0) begin
					$error("result with no item outstanding");
					errs++;
				end else begin
					want = expected_angles.pop_front();
					if (angle_first !== want.first) begin
						$error("angle_first expected %0d got %0d", want.first, angle_first);
						errs++;
					end
					if (angle_second !== want.second) begin
						$error("angle_second expected %0d got %0d", want.second,
							angle_second);
						errs++;
					end
					if (angle_third !== want.third) begin
						$error("angle_third expected %0d got %0d", want.third, angle_third);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_rotation_matrix_to_euler_angles.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the rotation matrix to Euler angle block.
// Depends on rmte_pkg, the block and euler_angle_checker.
`default_nettype none

module tb_rotation_matrix_to_euler_angles;
	import rmte_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [14:0]       cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic signed [15:0] mat_in[9];
	logic              out_valid;
	logic              out_stall;
	angle_t            angle_first;
	angle_t            angle_second;
	angle_t            angle_third;
	int                fail_count;
	int                angles_pending;
	logic              hold_off;

	rotation_matrix_to_euler_angles dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.m_r0_c0(mat_in[0]), .m_r0_c1(mat_in[1]), .m_r0_c2(mat_in[2]),
		.m_r1_c0(mat_in[3]), .m_r1_c1(mat_in[4]), .m_r1_c2(mat_in[5]),
		.m_r2_c0(mat_in[6]), .m_r2_c1(mat_in[7]), .m_r2_c2(mat_in[8]),
		.out_valid(out_valid), .out_stall(out_stall), .angle_first(angle_first),
		.angle_second(angle_second), .angle_third(angle_third)
	);

	euler_angle_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.m_r0_c0(mat_in[0]), .m_r0_c1(mat_in[1]), .m_r0_c2(mat_in[2]),
		.m_r1_c0(mat_in[3]), .m_r1_c1(mat_in[4]), .m_r1_c2(mat_in[5]),
		.m_r2_c0(mat_in[6]), .m_r2_c1(mat_in[7]), .m_r2_c2(mat_in[8]),
		.out_valid(out_valid), .out_stall(out_stall), .angle_first(angle_first),
		.angle_second(angle_second), .angle_third(angle_third),
		.fail_count(fail_count), .angles_pending(angles_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver stall: random gaps, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= (gap_len() != 0);
		end
	end

	// long receiver hold-off counted in its own process
	task automatic long_hold();
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	endtask

	// one register write, followed by a wait with cfg_we low
	task automatic write_reg(input logic idx, input logic [14:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item after a random gap; valid stays high for a back-to-back follower
	task automatic send_matrix(input logic signed [15:0] m[9]);
		int n;
		n = gap_len();
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		for (int k = 0; k < 9; k++) mat_in[k] <= m[k];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (angles_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// random field value: raw 16-bit, extremes, zero, or in range
	function automatic logic signed [15:0] rand_entry();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		if (r == 1) return 16'sd16384;
		if (r == 2) return -16'sd16384;
		if (r == 3) return 16'sd0;
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	// random matrix, or rotation-like: a signed permutation, sometimes with small random perturbation
	task automatic make_matrix(output logic signed [15:0] m[9]);
		int p[3];
		int t;
		int j;
		int kind;
		kind = $urandom_range(0, 9);
		p = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = p[i]; p[i] = p[j]; p[j] = t;
		end
		for (int k = 0; k < 9; k++) begin
			if (kind < 2) m[k] = rand_entry();
			else if (kind < 5) m[k] = 16'($urandom_range(0, 32768) - 16384);
			else begin
				m[k] = ((k % 3) == p[k / 3]) ? ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384)
					: 16'sd0;
				if (kind > 7) m[k] = m[k] + 16'($urandom_range(0, 64) - 32);
			end
		end
	endtask

	initial begin
		logic signed [15:0] m[9];
		logic [14:0] thresholds[4] = '{15'd0, 15'd1, 15'd300, 15'd16384};
		arst_n = 1'b0;
		hold_off = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ORDER;
		cfg_data = '0;
		in_valid = 1'b0;
		for (int k = 0; k < 9; k++) mat_in[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, extremes, zero, out-of-range under reset config
		m = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		m = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 16'sh7fff};
		send_matrix(m);
		m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384};
		send_matrix(m);
		m = '{0, 0, 16'sd16384, 0, 16'sd16384, 0, -16'sd16384, 0, 0};
		send_matrix(m);
		m = '{0, 0, -16'sd16384, 0, 16'sd16384, 0, 16'sd16384, 0, 0};
		send_matrix(m);
		m = '{16'sd11585, -16'sd11585, 0, 16'sd11585, 16'sd11585, 0, 0, 0, 16'sd16384};
		send_matrix(m);
		m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_matrix(m);
		drain();

		// every order code, including the unused axis codes, several thresholds
		for (int code = 0; code < 32; code++) begin
			write_reg(CFG_ORDER, 15'(code));
			write_reg(CFG_THRESHOLD, (code == 31) ? 15'h7fff : thresholds[code % 4]);
			for (int n = 0; n < 50; n++) begin
				make_matrix(m);
				if (code == 5 && n == 5) fork long_hold(); join_none
				send_matrix(m);
			end
			// pause the sender until everything has come out
			drain();
		end
		drain();
		if (fail_count == 0)
			$display("rotation_matrix_to_euler_angles test passed");
		else
			$display("rotation_matrix_to_euler_angles test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("rotation_matrix_to_euler_angles test failed");
		$finish;
	end

endmodule

`default_nettype wire
